[src/ffra_pkg.sv]
package ffra_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int ADDR_W = 32;
	localparam int PAGES_W = 21;
	localparam int PAGE_SHIFT = 12;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CHECK   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_USED_FULL = 3'd1,
		ST_ZERO      = 3'd2,
		ST_NO_FIT    = 3'd3,
		ST_FREE_FULL = 3'd4,
		ST_META      = 3'd5,
		ST_NOT_FOUND = 3'd6
	} status_t;

	localparam logic [1:0] REG_POOL_BASE = 2'd0;
	localparam logic [1:0] REG_POOL_BYTES = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_WAIT,
		S_HIT,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the input transaction
		logic clr_idx;
		logic inc_idx;
		logic rd_scan;    // read entry at scan index
		logic rd_last;    // read last entry of the scanned table
		logic apply_hit;  // write the first update of a hit
		logic apply_move; // write the moved entry into the hit slot
		logic set_fail;
		status_t fail_code;
		logic set_ok;
		logic present;
	} ffra_cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic used_full;
		logic free_full;
		logic zero_pages;
		logic is_meta;
		logic scan_end;
		logic match;
		logic exact;
		logic out_busy;
	} ffra_sts_t;

endpackage

[src/ffra_if.sv]
interface ffra_in_if;
	import ffra_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [31:0] request_bytes;
	logic [31:0] address;
	modport source(output valid, mode, request_bytes, address, input ready);
	modport sink(input valid, mode, request_bytes, address, output ready);
endinterface

interface ffra_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [31:0] region_base;
	logic [20:0] region_pages;
	logic is_inside;
	modport source(output valid, status, region_base, region_pages, is_inside, input ready);
	modport sink(input valid, status, region_base, region_pages, is_inside, output ready);
endinterface

[src/ffra_ctrl.sv]
module ffra_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ffra_pkg::ffra_sts_t sts,
	output ffra_pkg::ffra_cmd_t cmd
);
	import ffra_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECIDE;
			S_DECIDE: begin
				case (sts.mode)
					MODE_ALLOC:
						if (sts.used_full || sts.zero_pages) state_d = S_OUT;
						else state_d = S_SCAN;
					MODE_RELEASE:
						if (sts.free_full || sts.is_meta) state_d = S_OUT;
						else state_d = S_SCAN;
					MODE_CHECK: state_d = S_SCAN;
					default: state_d = S_OUT;
				endcase
			end
			S_SCAN: if (sts.scan_end) state_d = S_OUT;
				else state_d = S_WAIT;
			S_WAIT: if (sts.match) state_d = S_HIT;
				else state_d = S_SCAN;
			S_HIT: begin
				if (sts.mode == MODE_CHECK) state_d = S_OUT;
				else if (sts.mode == MODE_ALLOC && !sts.exact) state_d = S_OUT;
				else state_d = S_MOVE_RD;
			end
			S_MOVE_RD: state_d = S_MOVE_WR;
			S_MOVE_WR: state_d = S_OUT;
			S_OUT: if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.fail_code = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.clr_idx = 1'b1;
			end
			S_DECIDE: begin
				if (sts.mode == MODE_ALLOC) begin
					if (sts.used_full) begin
						cmd.set_fail = 1'b1; cmd.fail_code = ST_USED_FULL;
					end else if (sts.zero_pages) begin
						cmd.set_fail = 1'b1; cmd.fail_code = ST_ZERO;
					end
				end else if (sts.mode == MODE_RELEASE) begin
					if (sts.free_full) begin
						cmd.set_fail = 1'b1; cmd.fail_code = ST_FREE_FULL;
					end else if (sts.is_meta) begin
						cmd.set_fail = 1'b1; cmd.fail_code = ST_META;
					end
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					cmd.set_fail = 1'b1;
					if (sts.mode == MODE_ALLOC) cmd.fail_code = ST_NO_FIT;
					else if (sts.mode == MODE_RELEASE) cmd.fail_code = ST_NOT_FOUND;
					else cmd.fail_code = ST_OK;
				end else begin
					cmd.rd_scan = 1'b1;
				end
			end
			S_WAIT: if (!sts.match) cmd.inc_idx = 1'b1;
			S_HIT: begin
				cmd.set_ok = 1'b1;
				if (sts.mode != MODE_CHECK) cmd.apply_hit = 1'b1;
			end
			S_MOVE_RD: cmd.rd_last = 1'b1;
			S_MOVE_WR: cmd.apply_move = 1'b1;
			S_OUT: cmd.present = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

[src/ffra_dp.sv]
module ffra_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0] mode,
	input  logic [31:0] request_bytes,
	input  logic [31:0] address,
	input  ffra_pkg::ffra_cmd_t cmd,
	output ffra_pkg::ffra_sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [31:0] region_base,
	output logic [20:0] region_pages,
	output logic is_inside
);
	import ffra_pkg::*;

	// table memories
	logic [ADDR_W-1:0]  used_base_mem [MAX_ENTRIES];
	logic [PAGES_W-1:0] used_pages_mem [MAX_ENTRIES];
	logic [ADDR_W-1:0]  free_base_mem [MAX_ENTRIES];
	logic [PAGES_W-1:0] free_pages_mem [MAX_ENTRIES];

	logic [31:0] pool_base_q, pool_bytes_q;
	logic [CNT_W-1:0] used_cnt_q, free_cnt_q, idx_q;
	logic init_q; // tables need entry 0 rewritten
	mode_t mode_q;
	logic [31:0] addr_q;
	logic [PAGES_W-1:0] req_pages_q;
	logic zero_q;
	logic [ADDR_W-1:0] rd_base_q;
	logic [PAGES_W-1:0] rd_pages_q;
	logic [ADDR_W-1:0] hit_base_q;
	logic [PAGES_W-1:0] hit_pages_q;
	logic out_valid_q;
	status_t status_q;
	logic [31:0] rbase_q;
	logic [20:0] rpages_q;
	logic inside_q;
	// output register, holds the presented result while the next one is built
	status_t out_status_q;
	logic [31:0] out_base_q;
	logic [20:0] out_pages_q;
	logic out_inside_q;
	logic cfg_hit;

	// request size in pages, 33-bit add avoids wrap
	logic [32:0] req_sum;
	logic [20:0] req_pg;
	assign req_sum = {1'b0, request_bytes} + 33'(4095);
	assign req_pg = req_sum[32:PAGE_SHIFT];

	logic [19:0] pool_pg;
	assign pool_pg = pool_bytes_q[31:PAGE_SHIFT];

	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] used_top, free_top;
	assign idx = idx_q[IDX_W-1:0];
	assign used_top = used_cnt_q[IDX_W-1:0];
	assign free_top = free_cnt_q[IDX_W-1:0];

	// unknown register indexes are ignored
	assign cfg_hit = cfg_we && (cfg_index inside {REG_POOL_BASE, REG_POOL_BYTES});

	// compare on the entry just read
	logic [ADDR_W-1:0] off;
	logic [32:0] span;
	logic match;
	assign off = addr_q - rd_base_q;
	assign span = {rd_pages_q, 12'b0};
	always_comb begin
		case (mode_q)
			MODE_ALLOC:   match = rd_pages_q >= req_pages_q;
			MODE_RELEASE: match = rd_base_q == addr_q;
			MODE_CHECK:   match = {1'b0, off} < span;
			default:      match = 1'b0;
		endcase
	end

	logic scan_alloc;
	assign scan_alloc = (mode_q == MODE_ALLOC);

	// status toward controller
	always_comb begin
		sts.mode = mode_q;
		sts.used_full = used_cnt_q >= CNT_W'(MAX_ENTRIES);
		sts.free_full = free_cnt_q >= CNT_W'(MAX_ENTRIES);
		sts.zero_pages = zero_q;
		sts.is_meta = addr_q == pool_base_q;
		sts.scan_end = scan_alloc ? (idx_q >= free_cnt_q) : (idx_q >= used_cnt_q);
		sts.match = match;
		sts.exact = hit_pages_q == req_pages_q;
		sts.out_busy = out_valid_q && !out_ready;
	end

	// memory writes and reads
	always_ff @(posedge clk) begin
		if (init_q) begin
			used_base_mem[0] <= pool_base_q;
			used_pages_mem[0] <= PAGES_W'(1);
			free_base_mem[0] <= pool_base_q + 32'(4096);
			free_pages_mem[0] <= (pool_pg == 20'd0) ? '0 : PAGES_W'(pool_pg - 1'b1);
		end else if (cmd.apply_hit) begin
			if (mode_q == MODE_ALLOC) begin
				used_base_mem[used_top] <= hit_base_q;
				used_pages_mem[used_top] <= req_pages_q;
				if (hit_pages_q != req_pages_q) begin
					free_base_mem[idx] <= hit_base_q + {req_pages_q[19:0], 12'b0};
					free_pages_mem[idx] <= hit_pages_q - req_pages_q;
				end
			end else begin
				free_base_mem[free_top] <= hit_base_q;
				free_pages_mem[free_top] <= hit_pages_q;
			end
		end else if (cmd.apply_move) begin
			if (mode_q == MODE_ALLOC) begin
				free_base_mem[idx] <= rd_base_q;
				free_pages_mem[idx] <= rd_pages_q;
			end else begin
				used_base_mem[idx] <= rd_base_q;
				used_pages_mem[idx] <= rd_pages_q;
			end
		end
		// counts are already updated here, so the old last entry sits at the count
		if (cmd.rd_scan) begin
			rd_base_q <= scan_alloc ? free_base_mem[idx] : used_base_mem[idx];
			rd_pages_q <= scan_alloc ? free_pages_mem[idx] : used_pages_mem[idx];
		end else if (cmd.rd_last) begin
			rd_base_q <= scan_alloc ? free_base_mem[free_top] : used_base_mem[used_top];
			rd_pages_q <= scan_alloc ? free_pages_mem[free_top] : used_pages_mem[used_top];
		end
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			addr_q <= address;
			req_pages_q <= req_pg;
			zero_q <= req_pg == 21'd0;
		end
	end

	// hit capture happens at the compare cycle
	always_ff @(posedge clk) begin
		if (match) begin
			hit_base_q <= rd_base_q;
			hit_pages_q <= rd_pages_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			pool_bytes_q <= 32'd4096;
			used_cnt_q <= CNT_W'(1);
			free_cnt_q <= CNT_W'(1);
			init_q <= 1'b1;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
			rbase_q <= '0;
			rpages_q <= '0;
			inside_q <= 1'b0;
			out_status_q <= ST_OK;
			out_base_q <= '0;
			out_pages_q <= '0;
			out_inside_q <= 1'b0;
		end else begin
			init_q <= 1'b0;
			if (cfg_hit) begin
				if (cfg_index == REG_POOL_BASE) pool_base_q <= cfg_data;
				else pool_bytes_q <= cfg_data;
				used_cnt_q <= CNT_W'(1);
				free_cnt_q <= CNT_W'(1);
				init_q <= 1'b1;
			end
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.load) begin
				status_q <= ST_OK;
				rbase_q <= '0;
				rpages_q <= '0;
				inside_q <= 1'b0;
			end
			if (cmd.set_fail) status_q <= cmd.fail_code;
			if (cmd.set_ok) begin
				status_q <= ST_OK;
				case (mode_q)
					MODE_ALLOC: begin
						rbase_q <= hit_base_q;
						used_cnt_q <= used_cnt_q + 1'b1;
						if (hit_pages_q == req_pages_q) free_cnt_q <= free_cnt_q - 1'b1;
					end
					MODE_RELEASE: begin
						rbase_q <= hit_base_q;
						rpages_q <= hit_pages_q;
						free_cnt_q <= free_cnt_q + 1'b1;
						used_cnt_q <= used_cnt_q - 1'b1;
					end
					MODE_CHECK: inside_q <= 1'b1;
					default: ;
				endcase
			end
			// hand the finished result to the output register
			if (cmd.present) begin
				out_valid_q <= 1'b1;
				out_status_q <= status_q;
				out_base_q <= rbase_q;
				out_pages_q <= rpages_q;
				out_inside_q <= inside_q;
			end else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign region_base = out_base_q;
	assign region_pages = out_pages_q;
	assign is_inside = out_inside_q;

endmodule

[src/first_fit_region_allocator.sv]
// An early failure goes from the decision straight to the result; else each table entry
// scanned is read and then compared, and an exact fit or a release moves the last entry.
// One transaction at a time; the next is accepted once the result is in the output register,
// and a result still waiting there holds off only the presentation of the next result.
// Reset (arst_n low): pool_base 0, pool_bytes 4096, one metadata page allocated,
// table entry 0 rewritten in the first cycle after reset or any register write.
module first_fit_region_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	ffra_in_if.sink in_ch,
	ffra_out_if.source out_ch
);
	import ffra_pkg::*;

	ffra_cmd_t cmd;
	ffra_sts_t sts;

	ffra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	ffra_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mode(in_ch.mode), .request_bytes(in_ch.request_bytes), .address(in_ch.address),
		.cmd(cmd), .sts(sts),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(out_ch.status), .region_base(out_ch.region_base),
		.region_pages(out_ch.region_pages), .is_inside(out_ch.is_inside)
	);

endmodule
